FILE: hdl/dkst_pkg.sv
package dkst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 32;

    localparam int IDX_BITS     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int KEY_PORT_W   = 32;
    localparam int COUNT_PORT_W = 5;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(TABLE_DEPTH);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

endpackage

FILE: hdl/distinct_key_set_table.sv
// Channel  Direction  Signals                                      Moves
// in       input      i_in_valid, o_in_stall, i_cmd, i_key         one request
// out      output     o_out_valid, i_out_stall, o_found,           one result per request
//                     o_status, o_member_count
//
// A request reads the key store RAM one slot per cycle through its single registered
// read port, then a drain state finishes the last compare and a commit state performs
// the write-back and loads the output register.
// Reset clears the slot valid bits, the member count, the state, scan address and flags.
// A stalled result holds in the output register; the next request is still taken,
// and its commit waits until the output register is free.
module distinct_key_set_table
    import dkst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [KEY_PORT_W-1:0]   i_key,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_found,
    output logic [STATUS_W-1:0]     o_status,
    output logic [COUNT_PORT_W-1:0] o_member_count
);

    logic [KEY_BITS-1:0] key_store [TABLE_DEPTH];

    t_state                r_state,      n_state;
    logic [TABLE_DEPTH-1:0] r_slot_valid, n_slot_valid;
    logic [CNT_BITS-1:0]   r_count,      n_count;
    logic [IDX_BITS-1:0]   r_addr,       n_addr;
    logic                  r_cmp_vld,    n_cmp_vld;
    logic [IDX_BITS-1:0]   r_cmp_idx,    n_cmp_idx;
    logic                  r_hit,        n_hit;
    logic [IDX_BITS-1:0]   r_hit_idx,    n_hit_idx;
    logic                  r_free_ok,    n_free_ok;
    logic [IDX_BITS-1:0]   r_free_idx,   n_free_idx;
    logic [CMD_W-1:0]      r_cmd,        n_cmd;
    logic [KEY_BITS-1:0]   r_key,        n_key;
    logic                  r_out_vld,    n_out_vld;
    logic                  r_found,      n_found;
    logic [STATUS_W-1:0]   r_status,     n_status;
    logic [KEY_BITS-1:0]   r_rd_data;
    logic                  mem_we;
    logic                  out_free;
    logic                  accept;

    assign out_free = !r_out_vld || !i_out_stall;
    assign accept   = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        r_rd_data <= key_store[r_addr];
        if (mem_we) begin
            key_store[r_free_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_slot_valid = r_slot_valid;
        n_count      = r_count;
        n_addr       = r_addr;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free_ok    = r_free_ok;
        n_free_idx   = r_free_idx;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_out_vld    = r_out_vld && i_out_stall;
        n_found      = r_found;
        n_status     = r_status;
        mem_we       = 1'b0;

        // compare stage, one slot behind the read
        if (r_cmp_vld) begin
            if (r_slot_valid[r_cmp_idx] && (r_rd_data == r_key)) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end
            if (!r_slot_valid[r_cmp_idx] && !r_free_ok) begin
                n_free_ok  = 1'b1;
                n_free_idx = r_cmp_idx;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = i_cmd;
                    n_key     = KEY_BITS'(i_key);
                    n_addr    = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_addr;
                if (r_addr == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + IDX_BITS'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_found   = r_hit;
                    n_status  = ST_IGNORED;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (!r_hit) begin
                                if (r_free_ok) begin
                                    mem_we                   = 1'b1;
                                    n_slot_valid[r_free_idx] = 1'b1;
                                    n_count                  = r_count + CNT_BITS'(1);
                                    n_status                 = ST_ADDED;
                                end else begin
                                    n_status = ST_FULL;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_hit) begin
                                n_slot_valid[r_hit_idx] = 1'b0;
                                n_count                 = r_count - CNT_BITS'(1);
                                n_status                = ST_REMOVED;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_count      <= '0;
            r_addr       <= '0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_ok    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_slot_valid <= n_slot_valid;
            r_count      <= n_count;
            r_addr       <= n_addr;
            r_cmp_vld    <= n_cmp_vld;
            r_hit        <= n_hit;
            r_free_ok    <= n_free_ok;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_found    <= n_found;
        r_status   <= n_status;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_found        = r_found;
    assign o_status       = r_status;
    assign o_member_count = COUNT_PORT_W'(r_count);

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_slot_valid))
        else $error("member count differs from valid bits");

    a_no_compare_at_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_cmp_vld)
        else $error("compare pending at commit");

    a_added_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && ((r_status == ST_ADDED) || (r_status == ST_FULL))) |-> !r_found)
        else $error("insert result with key present");

    a_removed_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_status == ST_REMOVED)) |-> r_found)
        else $error("remove result with key absent");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_status == ST_FULL)) |-> (r_count == FULL_CNT))
        else $error("full reported below capacity");

endmodule

FILE: bench/set_checker.sv
module set_checker
    import dkst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [KEY_PORT_W-1:0]   i_key,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic                    i_found,
    input  logic [STATUS_W-1:0]     i_status,
    input  logic [COUNT_PORT_W-1:0] i_member_count,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic                    found;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_PORT_W-1:0] count;
    } t_set_result;

    logic [KEY_BITS-1:0] stored_key [TABLE_DEPTH];
    logic                slot_used  [TABLE_DEPTH];
    logic [CNT_BITS-1:0] members;
    t_set_result         awaited_results [$];
    int                  results_seen;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < 100) begin
            $display("%0t: result %0d: %s: got %0h, expected %0h",
                     $time, results_seen, what, got, want);
        end
        o_fail_count++;
    endtask

    // Applies one request to the shadow table and queues the result it must produce.
    task automatic predict_result(input logic [CMD_W-1:0] cmd,
                                  input logic [KEY_PORT_W-1:0] key_in);
        logic [KEY_BITS-1:0] k;
        int                  hit;
        int                  open_slot;
        t_set_result         r;
        k         = KEY_BITS'(key_in);
        hit       = -1;
        open_slot = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (slot_used[i] && stored_key[i] == k) begin
                hit = i;
            end
            if (!slot_used[i]) begin
                open_slot = i;
            end
        end
        r.found  = (hit >= 0);
        r.status = ST_IGNORED;
        if (cmd == CMD_INSERT && hit < 0) begin
            if (open_slot >= 0) begin
                stored_key[open_slot] = k;
                slot_used[open_slot]  = 1'b1;
                members               = members + CNT_BITS'(1);
                r.status              = ST_ADDED;
            end else begin
                r.status = ST_FULL;
            end
        end else if (cmd == CMD_REMOVE && hit >= 0) begin
            slot_used[hit] = 1'b0;
            members        = members - CNT_BITS'(1);
            r.status       = ST_REMOVED;
        end
        r.count = COUNT_PORT_W'(members);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic check_result();
        t_set_result want;
        results_seen++;
        if (awaited_results.size() == 0) begin
            report_mismatch("result with no request pending", 32'(i_status), 32'd0);
            return;
        end
        want = awaited_results.pop_front();
        if (i_found !== want.found) begin
            report_mismatch("found", 32'(i_found), 32'(want.found));
        end
        if (i_status !== want.status) begin
            report_mismatch("status", 32'(i_status), 32'(want.status));
        end
        if (i_member_count !== want.count) begin
            report_mismatch("member_count", 32'(i_member_count), 32'(want.count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_used[i] = 1'b0;
            end
            members = '0;
            awaited_results.delete();
        end else begin
            // results leave before the request taken at the same edge is predicted
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_result(i_cmd, i_key);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: bench/testbench.sv
module testbench;
    import dkst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 4 * (TABLE_DEPTH + 3) + 80;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        in_cmd    = CMD_LOOKUP;
    logic [KEY_PORT_W-1:0]   in_key    = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    found;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_PORT_W-1:0] member_count;
    int                      fail_count;
    int                      pending;
    int                      idle_cycles = 0;
    bit                      calm_in = 1'b0;
    int                      insert_bias = 50;
    logic [KEY_PORT_W-1:0]   key_pool [POOL_SIZE];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    distinct_key_set_table dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (in_cmd),
        .i_key          (in_key),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_found        (found),
        .o_status       (status),
        .o_member_count (member_count)
    );

    set_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_cmd          (in_cmd),
        .i_key          (in_key),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_found        (found),
        .i_status       (status),
        .i_member_count (member_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // mostly short pauses, now and then a long one
    function automatic int rand_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 3);
        end else if (r < 90) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [KEY_PORT_W-1:0] key);
        int gap;
        gap = (calm_in || $urandom_range(0, 1) == 0) ? 0 : rand_pause();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_cmd   <= 2'($urandom);
            in_key   <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_key   <= key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Removes every pool key, then draws a new pool with some near-duplicate keys.
    task automatic retire_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            send_request(CMD_REMOVE, key_pool[i]);
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i > 0 && $urandom_range(0, 2) == 0) begin
                key_pool[i] = key_pool[$urandom_range(0, i - 1)]
                              ^ (32'h1 << $urandom_range(0, 31));
            end else begin
                key_pool[i] = $urandom;
            end
        end
    endtask

    task automatic random_request();
        logic [CMD_W-1:0] cmd;
        int               q;
        if ($urandom_range(0, 99) < 5) begin
            // stray keys, never inserted so they cannot clog the table
            case ($urandom_range(0, 2))
                0:       cmd = CMD_REMOVE;
                1:       cmd = CMD_LOOKUP;
                default: cmd = CMD_SPARE;
            endcase
            send_request(cmd, $urandom);
        end else begin
            q = $urandom_range(0, 99);
            if (q < insert_bias) begin
                cmd = CMD_INSERT;
            end else if (q < insert_bias + (100 - insert_bias) * 2 / 3) begin
                cmd = CMD_REMOVE;
            end else if ($urandom_range(0, 9) == 0) begin
                cmd = CMD_SPARE;
            end else begin
                cmd = CMD_LOOKUP;
            end
            send_request(cmd, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
    endtask

    initial begin : out_stall_gen
        int run_len;
        bit calm_out;
        forever begin
            calm_out = ($urandom_range(0, 4) == 0);
            run_len  = calm_out ? $urandom_range(60, 200) : $urandom_range(1, 12);
            repeat (run_len) @(negedge clk) out_stall <= 1'b0;
            if (!calm_out) begin
                run_len = rand_pause();
                repeat (run_len) @(negedge clk) out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 0; i < 14; i++) begin
            key_pool[2 + i] = 32'h1 << i;
        end
        key_pool[16] = 32'h8000_0000;
        for (int i = 17; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(CMD_LOOKUP, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_SPARE,  32'h0000_0000);
        for (int i = 0; i < 14; i++) begin
            send_request(CMD_INSERT, 32'h1 << i);
        end
        // table is full now
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'h0000_0020);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                calm_in = ($urandom_range(0, 3) == 0);
            end
            if (n % 100 == 0) begin
                insert_bias = $urandom_range(20, 80);
            end
            if (n % 400 == 399) begin
                retire_pool();
            end
            random_request();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/dkst_pkg.sv
hdl/distinct_key_set_table.sv
bench/set_checker.sv
bench/testbench.sv
